// File: design/lrs_pkg.sv
// shared types and constants for the line repeat suppressor
// no dependencies; imported by every module of the block
package lrs_pkg;

    localparam int HASH_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int TOTAL_W     = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [HASH_W-1:0]  HASH_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0]  HASH_PRIME = 32'd16777619;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] KEEP_RESET = 16'd3;

    // finished line handed from the hashing front to the probing back
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              tracked;
    } line_req_t;

    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [COUNT_W-1:0] count;
    } slot_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } back_state_t;

endpackage

// File: design/lrs_front.sv
// hashing front: folds line bytes into fnv-1a and pushes finished lines
// depends on lrs_pkg
module lrs_front
    import lrs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clearing,
    input  logic            q_full,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      line_byte,
    input  logic            line_end,
    input  logic            tracked,
    output logic            push,
    output line_req_t       push_data
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] folded;
    logic              accept;

    assign in_ready = !clearing && !q_full;
    assign accept   = in_valid && in_ready;
    assign mixed    = hash_reg ^ {{(HASH_W-8){1'b0}}, line_byte};
    // multiply by a constant with few set bits, kept modulo 2^32
    assign folded   = HASH_W'(mixed * HASH_PRIME);

    assign push              = accept && line_end;
    assign push_data.hash    = folded | {{(HASH_W-1){1'b0}}, 1'b1};
    assign push_data.tracked = tracked;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = line_end ? HASH_BASIS : folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// File: design/lrs_queue.sv
// short fifo of finished lines between the hashing front and the prober
// depends on lrs_pkg
module lrs_queue
    import lrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  line_req_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      q_valid,
    output line_req_t q_data
);

    line_req_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/lrs_back.sv
// probing back end: slot table, linear probe sequencer, counters and result register
// depends on lrs_pkg
module lrs_back
    import lrs_pkg::*;
#(
    parameter int SLOTS      = 2048,
    parameter int MAX_PROBES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               q_valid,
    input  line_req_t          q_data,
    output logic               q_pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               drop,
    output logic               new_entry,
    output logic               crowded,
    output logic [COUNT_W-1:0] seen_count,
    output logic [TOTAL_W-1:0] suppressed_total
);

    localparam int  SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int  PW   = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
    localparam bit  POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [SW-1:0] LAST_SLOT  = SW'(SLOTS - 1);
    localparam logic [PW-1:0] LAST_PROBE = PW'(MAX_PROBES - 1);
    // reciprocal of SLOTS scaled by 2^(32+SW), rounded up: exact quotient for any hash
    localparam logic [63:0]     RECIP_FULL = ((64'd1 << (HASH_W + SW)) + 64'(SLOTS) - 64'd1)
                                             / 64'(SLOTS);
    localparam logic [HASH_W:0] RECIP      = RECIP_FULL[HASH_W:0];

    back_state_t         state_reg;
    back_state_t         state_next;

    slot_entry_t         slot_mem [SLOTS];
    slot_entry_t         rd_data_reg;
    slot_entry_t         mem_wdata;
    logic [SW-1:0]       mem_waddr;
    logic                mem_we;
    logic                mem_re;

    logic [SW-1:0]       clr_idx_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic                tracked_reg;
    logic [SW-1:0]       slot_reg;
    logic                mod_step_reg;
    logic [HASH_W-1:0]   quot_reg;
    logic [PW-1:0]       probe_reg;
    logic [COUNT_W-1:0]  keep_reg;
    logic [TOTAL_W-1:0]  total_reg;

    logic                res_drop_reg;
    logic                res_new_reg;
    logic                res_crowd_reg;
    logic [COUNT_W-1:0]  res_count_reg;

    logic                out_valid_reg;
    logic                drop_reg;
    logic                new_reg;
    logic                crowd_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [TOTAL_W-1:0]  total_out_reg;

    logic                load_out;
    logic                hit;
    logic                empty_slot;
    logic                last_probe;
    logic                clear_last;
    logic [COUNT_W-1:0]  cnt_inc;
    logic                over_keep;
    logic [2*HASH_W:0]   recip_prod;
    logic [HASH_W-1:0]   quot_val;
    logic [HASH_W-1:0]   quot_mul;
    logic [SW-1:0]       mod_rem;
    logic [SW-1:0]       slot_inc;

    assign hit        = (rd_data_reg.hash == hash_reg);
    assign empty_slot = (rd_data_reg.hash == '0);
    assign last_probe = (probe_reg == LAST_PROBE);
    assign clear_last = (clr_idx_reg == LAST_SLOT);
    assign cnt_inc    = (rd_data_reg.count == COUNT_MAX) ? COUNT_MAX
                                                         : rd_data_reg.count + 1'b1;
    assign over_keep  = (cnt_inc > keep_reg);
    // hash mod SLOTS: quotient by reciprocal into quot_reg, then remainder into slot_reg
    assign recip_prod = (2*HASH_W+1)'(hash_reg) * (2*HASH_W+1)'(RECIP);
    assign quot_val   = HASH_W'(recip_prod >> (HASH_W + SW));
    assign quot_mul   = quot_reg * HASH_W'(SLOTS);
    assign mod_rem    = SW'(hash_reg - quot_mul);
    assign slot_inc   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (!q_data.tracked)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (POW2)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_step_reg)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (hit || empty_slot || last_probe)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        clearing  = 1'b0;
        q_pop     = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = slot_reg;
        mem_wdata = '0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
            end
            ST_IDLE:
            begin
                q_pop = q_valid;
            end
            ST_MOD:
            begin
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.hash  = hash_reg;
                    mem_wdata.count = cnt_inc;
                end
                else if (empty_slot)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.hash  = hash_reg;
                    mem_wdata.count = COUNT_W'(1);
                end
            end
            ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            keep_reg      <= KEEP_RESET;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                keep_reg <= cfg_wdata;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (state_reg == ST_CHECK && hit && over_keep)
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // probe datapath and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                hash_reg      <= q_data.hash;
                tracked_reg   <= q_data.tracked;
                mod_step_reg  <= 1'b0;
                probe_reg     <= '0;
                slot_reg      <= POW2 ? q_data.hash[SW-1:0] : '0;
                res_drop_reg  <= 1'b0;
                res_new_reg   <= 1'b0;
                res_crowd_reg <= 1'b0;
                res_count_reg <= '0;
            end
            ST_MOD:
            begin
                if (!mod_step_reg)
                begin
                    quot_reg     <= quot_val;
                    mod_step_reg <= 1'b1;
                end
                else
                begin
                    slot_reg <= mod_rem;
                end
            end
            ST_CHECK:
            begin
                if (hit)
                begin
                    res_count_reg <= cnt_inc;
                    res_drop_reg  <= over_keep;
                end
                else if (empty_slot)
                begin
                    res_count_reg <= COUNT_W'(1);
                    res_new_reg   <= 1'b1;
                end
                else if (last_probe)
                begin
                    res_crowd_reg <= 1'b1;
                end
                else
                begin
                    slot_reg  <= slot_inc;
                    probe_reg <= probe_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            drop_reg      <= res_drop_reg;
            new_reg       <= res_new_reg;
            crowd_reg     <= res_crowd_reg;
            count_reg     <= res_count_reg;
            total_out_reg <= total_reg;
        end
    end

    // slot table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[slot_reg];
        end
    end

    assign out_valid        = out_valid_reg;
    assign drop             = drop_reg;
    assign new_entry        = new_reg;
    assign crowded          = crowd_reg;
    assign seen_count       = count_reg;
    assign suppressed_total = total_out_reg;

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("line taken from queue during table clear");

    a_write_only_clear_or_check: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_CHECK))
        else $error("slot table written outside clear or check");

    a_total_moves_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CHECK) |=> $stable(total_reg))
        else $error("suppressed total changed outside a probe check");

    a_untracked_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> tracked_reg)
        else $error("untracked line probed the table");

    a_result_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $countones({drop_reg, new_reg, crowd_reg}) <= 1)
        else $error("more than one result flag set");

endmodule

// File: design/line_repeat_suppressor.sv
// a byte that does not end a line only folds into the hash and gives no result
// a line end is queued; the prober pops it, reduces the hash modulo SLOTS when SLOTS is
// not a power of two, then reads and checks a slot per probe; untracked lines skip all that
// throughput: one byte per cycle while the queue has room and no clear runs; the prober takes
// one line at a time and waits with a finished result until the receiver has taken the last one
// reset: the slot table is swept to empty slot by slot, in_ready low throughout
module line_repeat_suppressor
    import lrs_pkg::*;
#(
    parameter int SLOTS      = 2048,
    parameter int MAX_PROBES = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         line_byte,
    input  logic               line_end,
    input  logic               tracked,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               drop,
    output logic               new_entry,
    output logic               crowded,
    output logic [COUNT_W-1:0] seen_count,
    output logic [TOTAL_W-1:0] suppressed_total
);

    logic      clearing;
    logic      q_full;
    logic      push;
    line_req_t push_data;
    logic      q_pop;
    logic      q_valid;
    line_req_t q_data;

    lrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .q_full    (q_full),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .line_byte (line_byte),
        .line_end  (line_end),
        .tracked   (tracked),
        .push      (push),
        .push_data (push_data)
    );

    lrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    lrs_back #(
        .SLOTS      (SLOTS),
        .MAX_PROBES (MAX_PROBES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drop             (drop),
        .new_entry        (new_entry),
        .crowded          (crowded),
        .seen_count       (seen_count),
        .suppressed_total (suppressed_total)
    );

endmodule

// File: dv/tb_line_repeat_suppressor.sv
// self-checking testbench for line_repeat_suppressor: hashes each byte transfer in a
// local copy of the slot table and compares every line verdict with it
// depends on lrs_pkg and the line_repeat_suppressor rtl
`timescale 1ns / 1ps

module tb_line_repeat_suppressor;
    import lrs_pkg::*;

    localparam int TB_SLOTS     = 2048;
    localparam int TB_PROBES    = 32;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int CLUSTER_SIZE = TB_PROBES + 1;

    typedef struct packed {
        logic               drop;
        logic               new_entry;
        logic               crowded;
        logic [COUNT_W-1:0] seen_count;
        logic [TOTAL_W-1:0] total;
    } line_verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         line_byte = 8'h00;
    logic               line_end = 1'b0;
    logic               tracked = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               drop;
    logic               new_entry;
    logic               crowded;
    logic [COUNT_W-1:0] seen_count;
    logic [TOTAL_W-1:0] suppressed_total;

    // local copy of the block state
    logic [HASH_W-1:0]  model_hash;
    logic [HASH_W-1:0]  model_slot_hash  [TB_SLOTS];
    logic [COUNT_W-1:0] model_slot_count [TB_SLOTS];
    logic [TOTAL_W-1:0] model_dropped;
    logic [COUNT_W-1:0] keep_model;

    line_verdict_t verdict_q [$];

    int errors        = 0;
    int bytes_sent    = 0;
    int lines_checked = 0;
    int drops_seen    = 0;
    int crowded_seen  = 0;
    int claims_seen   = 0;
    int quiet_cycles  = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int hold_token    = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    line_repeat_suppressor #(
        .SLOTS      (TB_SLOTS),
        .MAX_PROBES (TB_PROBES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .line_byte        (line_byte),
        .line_end         (line_end),
        .tracked          (tracked),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .drop             (drop),
        .new_entry        (new_entry),
        .crowded          (crowded),
        .seen_count       (seen_count),
        .suppressed_total (suppressed_total)
    );

    always #2 clk = ~clk;

    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        return (h ^ {24'd0, b}) * HASH_PRIME;
    endfunction

    // folds one accepted byte; a tracked line end probes the table, every line end queues the verdict
    task automatic fold_transfer(input logic [7:0] b, input logic e, input logic t);
        logic [HASH_W-1:0] h;
        int unsigned       slot;
        bit                found;
        line_verdict_t     v;
        h = fnv_fold(model_hash, b);
        if (!e)
        begin
            model_hash = h;
            return;
        end
        model_hash = HASH_BASIS;
        h[0] = 1'b1;
        v = '0;
        if (t)
        begin
            found = 1'b0;
            slot  = h % TB_SLOTS;
            for (int p = 0; p < TB_PROBES && !found; p++)
            begin
                if (model_slot_hash[slot] == h)
                begin
                    if (model_slot_count[slot] < COUNT_MAX)
                        model_slot_count[slot] = model_slot_count[slot] + 1'b1;
                    v.seen_count = model_slot_count[slot];
                    if (v.seen_count > keep_model)
                    begin
                        v.drop = 1'b1;
                        model_dropped = model_dropped + 1'b1;
                    end
                    found = 1'b1;
                end
                else if (model_slot_hash[slot] == '0)
                begin
                    model_slot_hash[slot]  = h;
                    model_slot_count[slot] = 16'd1;
                    v.seen_count = 16'd1;
                    v.new_entry  = 1'b1;
                    found = 1'b1;
                end
                else
                begin
                    slot = (slot + 1 == TB_SLOTS) ? 0 : slot + 1;
                end
            end
            if (!found)
                v.crowded = 1'b1;
        end
        v.total = model_dropped;
        verdict_q.push_back(v);
    endtask

    // watches both channels and the register port at every edge
    always @(posedge clk)
    begin
        line_verdict_t want;
        if (rst_n)
        begin
            if (cfg_we)
                keep_model = cfg_wdata;
            if (in_valid && in_ready)
                fold_transfer(line_byte, line_end, tracked);
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result transfer with no line outstanding");
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    lines_checked++;
                    drops_seen   += want.drop;
                    crowded_seen += want.crowded;
                    claims_seen  += want.new_entry;
                    if (drop !== want.drop)
                    begin
                        $error("drop: expected %0d, got %0d", want.drop, drop);
                        errors++;
                    end
                    if (new_entry !== want.new_entry)
                    begin
                        $error("new_entry: expected %0d, got %0d", want.new_entry, new_entry);
                        errors++;
                    end
                    if (crowded !== want.crowded)
                    begin
                        $error("crowded: expected %0d, got %0d", want.crowded, crowded);
                        errors++;
                    end
                    if (seen_count !== want.seen_count)
                    begin
                        $error("seen_count: expected %0d, got %0d", want.seen_count, seen_count);
                        errors++;
                    end
                    if (suppressed_total !== want.total)
                    begin
                        $error("suppressed_total: expected %0d, got %0d",
                               want.total, suppressed_total);
                        errors++;
                    end
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // receiver: random stalls, plus a long hold-off whenever a new token is raised
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_token)
        begin
            hold_served <= hold_token;
            hold_left   <= HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("tb_line_repeat_suppressor: done, errors");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic e, input logic t);
        if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_gap_pct);
        end
        in_valid  <= 1'b1;
        line_byte <= b;
        line_end  <= e;
        tracked   <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // tracked is only meaningful on the last byte, so the others carry noise
    task automatic send_text(input logic [7:0] text [12], input int len, input logic t);
        for (int i = 0; i < len; i++)
        begin
            if (i == len - 1)
                send_byte(text[i], 1'b1, t);
            else
                send_byte(text[i], 1'b0, 1'($urandom_range(1)));
        end
    endtask

    // wait until every line has its verdict and the prober has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_keep(input logic [COUNT_W-1:0] value);
        settle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // reset keep limit of 3, untracked lines and the byte extremes
    task automatic test_basic_repeats();
        logic [7:0] text [12];
        in_gap_pct    = 0;
        out_stall_pct = 0;
        text = '{default: 8'h00};
        text[0] = 8'h41;
        repeat (5)
            send_text(text, 1, 1'b1);
        text[0] = 8'hFF;
        send_text(text, 1, 1'b0);
        text[0] = 8'h00;
        text[1] = 8'hFF;
        text[2] = 8'h55;
        text[3] = 8'hAA;
        send_text(text, 4, 1'b1);
        send_text(text, 4, 1'b0);
        send_text(text, 4, 1'b1);
    endtask

    // keep limit of zero: the claiming line is kept, the first repeat dropped
    task automatic test_keep_extremes();
        logic [7:0] text [12];
        text = '{default: 8'h00};
        text[0] = 8'h80;
        text[1] = 8'h01;
        write_keep(16'd0);
        send_text(text, 2, 1'b1);
        send_text(text, 2, 1'b1);
    endtask

    // lines that all land on one home slot, one more than the probe depth
    task automatic test_crowded_table();
        logic [23:0]       code_q [$];
        logic [HASH_W-1:0] hash_q [$];
        logic [HASH_W-1:0] h;
        logic [7:0]        text [12];
        int unsigned       home;
        int unsigned       code;
        bit                dup;
        write_keep(16'd3);
        text = '{default: 8'h00};
        code = 32'h003A_0000;
        while (code_q.size() < CLUSTER_SIZE)
        begin
            h = fnv_fold(fnv_fold(fnv_fold(HASH_BASIS, code[7:0]), code[15:8]), code[23:16]);
            h[0] = 1'b1;
            if (code_q.size() == 0)
                home = h % TB_SLOTS;
            dup = 1'b0;
            foreach (hash_q[k])
                if (hash_q[k] == h)
                    dup = 1'b1;
            if (!dup && (h % TB_SLOTS) == home)
            begin
                code_q.push_back(code[23:0]);
                hash_q.push_back(h);
            end
            code++;
        end
        foreach (code_q[k])
        begin
            {text[2], text[1], text[0]} = code_q[k];
            send_text(text, 3, 1'b1);
        end
        // the overflow line again, tracked and then untracked, then a hit deep in the cluster
        send_text(text, 3, 1'b1);
        send_text(text, 3, 1'b0);
        {text[2], text[1], text[0]} = code_q[TB_PROBES - 1];
        send_text(text, 3, 1'b1);
    endtask

    // keep limit at its maximum keeps every repeat; lowering it drops the next ones
    task automatic test_keep_maximum();
        write_keep(COUNT_MAX);
        repeat (6)
            send_byte(8'h7E, 1'b1, 1'b1);
        write_keep(16'd0);
        repeat (2)
            send_byte(8'h7E, 1'b1, 1'b1);
    endtask

    // receiver holds off while lines keep coming, so the input side backs up
    task automatic test_pressure();
        logic [7:0] text [12];
        write_keep(16'd2);
        in_gap_pct    = 0;
        out_stall_pct = 0;
        text = '{default: 8'h00};
        hold_token++;
        for (int i = 0; i < 40; i++)
        begin
            text[0] = 8'hC0 + 8'(i % 5);
            text[1] = 8'(i % 5) ^ 8'h3C;
            send_text(text, 2, 1'b1);
        end
    endtask

    // mostly repeats drawn from a small pool, with fresh lines and cut-short lines
    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input logic [COUNT_W-1:0] keep, input int budget);
        logic [7:0] pool_text [16][12];
        int         pool_len  [16];
        logic [7:0] text [12];
        int         start;
        int         pick;
        int         roll;
        int         len;
        write_keep(keep);
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
        for (int p = 0; p < 16; p++)
        begin
            pool_len[p] = (p == 0) ? 12 : $urandom_range(1, 6);
            for (int i = 0; i < 12; i++)
                pool_text[p][i] = 8'($urandom_range(255));
        end
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            roll = $urandom_range(99);
            pick = $urandom_range(15);
            if (roll < 75)
            begin
                send_text(pool_text[pick], pool_len[pick], $urandom_range(99) < 90);
            end
            else if (roll < 90)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < 12; i++)
                    text[i] = 8'($urandom_range(255));
                send_text(text, len, 1'($urandom_range(1)));
            end
            else
            begin
                len = $urandom_range(1, pool_len[pick]);
                send_text(pool_text[pick], len, 1'b1);
            end
        end
    endtask

    initial
    begin
        for (int s = 0; s < TB_SLOTS; s++)
        begin
            model_slot_hash[s]  = '0;
            model_slot_count[s] = '0;
        end
        model_hash    = HASH_BASIS;
        model_dropped = '0;
        keep_model    = KEEP_RESET;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        test_basic_repeats();
        test_keep_extremes();
        test_crowded_table();
        test_keep_maximum();
        test_pressure();
        test_random_traffic(0, 0, 16'd1, 350);
        test_random_traffic(63, 0, 16'd2, 350);
        test_random_traffic(0, 63, 16'd0, 350);
        test_random_traffic(36, 36, 16'($urandom_range(0, 4)), 350);
        settle();

        $display("covered %0d byte transfers and %0d line verdicts across keep limits 0 to %0d",
                 bytes_sent, lines_checked, COUNT_MAX);
        $display("verdicts: %0d dropped, %0d new slots, %0d crowded",
                 drops_seen, claims_seen, crowded_seen);
        if (errors == 0)
            $display("tb_line_repeat_suppressor: done, clean");
        else
            $display("tb_line_repeat_suppressor: done, errors");
        $finish;
    end

endmodule

// File: files.f
design/lrs_pkg.sv
design/lrs_front.sv
design/lrs_queue.sv
design/lrs_back.sv
design/line_repeat_suppressor.sv
dv/tb_line_repeat_suppressor.sv
